FILE: hw/rtl/rar_pkg.sv
// Shared types and constants for the rational add-and-reduce block.
// No dependencies; imported by rational_add_reduce_top and the testbench.
package rar_pkg;

	// Fixed widths of the result fields
	localparam int NUM_W = 33;
	localparam int DEN_W = 31;

	// Sequencer states, one-hot
	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_MUL_AB = 8'b0000_0010,
		ST_MUL_BA = 8'b0000_0100,
		ST_MUL_DD = 8'b0000_1000,
		ST_SETUP  = 8'b0001_0000,
		ST_GCD    = 8'b0010_0000,
		ST_DIV_N  = 8'b0100_0000,
		ST_DIV_D  = 8'b1000_0000
	} rar_state_t;

endpackage

FILE: hw/rtl/rational_add_reduce_top.sv
// A zero denominator gives done and den_error straight from idle; otherwise the
// sequencer steps through ST_MUL_AB, ST_MUL_BA, ST_MUL_DD and ST_SETUP, then
// data-dependent binary GCD steps, then two restoring divisions (numerator, then
// denominator) on the shared subtractor, then raises done with the reduced sum.
// One item at a time: start is accepted only in idle.
// Reset clears the sequencer and the done strobe; the receiver cannot stall.
module rational_add_reduce_top
	import rar_pkg::*;
#(
	parameter int OPERAND_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [OPERAND_BITS-1:0] a_num,
	input  logic signed [OPERAND_BITS-1:0] a_den,
	input  logic signed [OPERAND_BITS-1:0] b_num,
	input  logic signed [OPERAND_BITS-1:0] b_den,
	output logic                           done,
	output logic signed [NUM_W-1:0]        sum_num,
	output logic        [DEN_W-1:0]        sum_den,
	output logic                           den_error
);

	localparam int PW = 2 * OPERAND_BITS;        // product width
	localparam int MW = 2 * OPERAND_BITS;        // magnitude width
	localparam int SW = PW + 1;                  // cross sum width
	localparam int CW = $clog2(MW);              // division bit counter
	localparam int KW = $clog2(MW + 1);          // common power-of-two count
	localparam int EW = (MW + 1 > NUM_W) ? MW + 1 : NUM_W;

	rar_state_t state_q;

	logic signed [OPERAND_BITS-1:0] an_q, ad_q, bn_q, bd_q;
	logic signed [PW-1:0] prod_q, acc_q;
	logic [MW-1:0] nmag_q, dmag_q, x_q, y_q, g_q, div_q, rem_q, nq_q;
	logic [KW-1:0] k_q;
	logic [CW-1:0] cnt_q;
	logic          nneg_q, dneg_q;
	logic          done_q, err_q;
	logic signed [NUM_W-1:0] sum_num_q;
	logic        [DEN_W-1:0] sum_den_q;

	// Shared multiplier: operands chosen by the sequencer
	logic signed [OPERAND_BITS-1:0] mul_a, mul_b;
	logic signed [PW-1:0]           mul_p;

	always_comb begin
		mul_a = an_q;
		mul_b = bd_q;
		case (state_q)
			ST_MUL_BA: begin
				mul_a = ad_q;
				mul_b = bn_q;
			end
			ST_MUL_DD: begin
				mul_a = ad_q;
				mul_b = bd_q;
			end
			default: begin
				mul_a = an_q;
				mul_b = bd_q;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Cross sum and magnitudes
	logic signed [SW-1:0] num_sum, num_neg;
	logic        [MW-1:0] num_mag;
	logic signed [PW-1:0] den_neg;
	logic        [MW-1:0] den_mag;

	assign num_sum = SW'(acc_q) + SW'(prod_q);
	assign num_neg = -num_sum;
	assign num_mag = num_sum[SW-1] ? num_neg[MW-1:0] : num_sum[MW-1:0];
	assign den_neg = -prod_q;
	assign den_mag = prod_q[PW-1] ? den_neg[MW-1:0] : prod_q[MW-1:0];

	// Shared compare/subtract unit: GCD steps and restoring division
	logic [MW:0]   rem_sh;
	logic [MW:0]   sub_a, sub_b;
	logic [MW+1:0] sub_d;
	logic          sub_ge;

	assign rem_sh = {rem_q, div_q[MW-1]};

	always_comb begin
		if (state_q == ST_GCD) begin
			sub_a = {1'b0, x_q};
			sub_b = {1'b0, y_q};
		end else begin
			sub_a = rem_sh;
			sub_b = {1'b0, g_q};
		end
	end

	assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_ge = !sub_d[MW+1];

	// Next remainder and quotient of one division step
	logic [MW-1:0] rem_nx, quo_nx;

	assign rem_nx = sub_ge ? sub_d[MW-1:0] : rem_sh[MW-1:0];
	assign quo_nx = {div_q[MW-2:0], sub_ge};

	// Final sign and masking to the result widths
	logic [EW-1:0] num_ext, num_ext_neg, den_ext;
	logic          res_neg;

	assign num_ext     = EW'(nq_q);
	assign num_ext_neg = -num_ext;
	assign den_ext     = EW'(quo_nx);
	assign res_neg     = (nq_q != '0) && (nneg_q != dneg_q);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (a_den == '0 || b_den == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_MUL_AB;
						end
					end
				end
				ST_MUL_AB: state_q <= ST_MUL_BA;
				ST_MUL_BA: state_q <= ST_MUL_DD;
				ST_MUL_DD: state_q <= ST_SETUP;
				ST_SETUP:  state_q <= ST_GCD;
				ST_GCD: begin
					if (x_q == '0) begin
						state_q <= ST_DIV_N;
					end
				end
				ST_DIV_N: begin
					if (cnt_q == '0) begin
						state_q <= ST_DIV_D;
					end
				end
				ST_DIV_D: begin
					if (cnt_q == '0) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				// capture the item; flag a zero denominator at once
				if (start) begin
					an_q   <= a_num;
					ad_q   <= a_den;
					bn_q   <= b_num;
					bd_q   <= b_den;
					dneg_q <= a_den[OPERAND_BITS-1] ^ b_den[OPERAND_BITS-1];
					if (a_den == '0 || b_den == '0) begin
						err_q     <= 1'b1;
						sum_num_q <= '0;
						sum_den_q <= '0;
					end
				end
			end
			ST_MUL_AB: prod_q <= mul_p;
			ST_MUL_BA: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			ST_MUL_DD: begin
				// cross sum done; denominator product comes in now
				nneg_q <= num_sum[SW-1];
				nmag_q <= num_mag;
				x_q    <= num_mag;
				prod_q <= mul_p;
			end
			ST_SETUP: begin
				dmag_q <= den_mag;
				y_q    <= den_mag;
				k_q    <= '0;
			end
			ST_GCD: begin
				// binary GCD: strip twos, then subtract the smaller odd value
				if (x_q == '0) begin
					g_q   <= y_q << k_q;
					div_q <= nmag_q;
					rem_q <= '0;
					cnt_q <= CW'(MW - 1);
				end else if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (sub_ge) begin
					x_q <= sub_d[MW-1:0];
				end else begin
					x_q <= y_q;
					y_q <= x_q;
				end
			end
			ST_DIV_N: begin
				// one quotient bit per cycle; reload for the denominator
				if (cnt_q == '0) begin
					nq_q  <= quo_nx;
					div_q <= dmag_q;
					rem_q <= '0;
					cnt_q <= CW'(MW - 1);
				end else begin
					div_q <= quo_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			ST_DIV_D: begin
				if (cnt_q == '0) begin
					err_q     <= 1'b0;
					sum_num_q <= res_neg ? num_ext_neg[NUM_W-1:0] : num_ext[NUM_W-1:0];
					sum_den_q <= den_ext[DEN_W-1:0];
				end else begin
					div_q <= quo_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign sum_num   = sum_num_q;
	assign sum_den   = sum_den_q;
	assign den_error = err_q;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for rational_add_reduce_top: directed rows, then random fraction pairs.
// Each item's expected reduced sum (from the table or computed in the bench) is compared at the done strobe.
// Depends on rar_pkg and rational_add_reduce_top.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rar_pkg::*;

	localparam int OPERAND_BITS = 16;
	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 12;
	localparam int ITEM_COUNT   = 700;
	localparam int DRAIN_CYCLES = 300;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int MAX_REPORTS  = 10;

	// Row kinds: expected sum written in the table, or computed by the predictor
	localparam bit WORKED  = 1'b1;
	localparam bit PREDICT = 1'b0;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic             err;
	} sum_t;

	typedef struct {
		int   an;
		int   ad;
		int   bn;
		int   bd;
		bit   kind;
		sum_t res;
	} operand_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           start = 1'b0;
	logic                           busy;
	logic signed [OPERAND_BITS-1:0] a_num = '0;
	logic signed [OPERAND_BITS-1:0] a_den = '0;
	logic signed [OPERAND_BITS-1:0] b_num = '0;
	logic signed [OPERAND_BITS-1:0] b_den = '0;
	logic                           done;
	logic signed [NUM_W-1:0]        sum_num;
	logic        [DEN_W-1:0]        sum_den;
	logic                           den_error;

	sum_t pending_sums[$];
	int   mismatches = 0;
	int   burst_left = 0;

	// Directed rows: zero denominators, zero sums, sign and extreme cases
	operand_row_t dir_rows[] = '{
		'{0, 1, 0, 1, WORKED, '{33'd0, 31'd1, 1'b0}},
		'{1, 1, 1, 1, WORKED, '{33'd2, 31'd1, 1'b0}},
		'{1, 0, 1, 1, WORKED, '{33'd0, 31'd0, 1'b1}},
		'{1, 1, 1, 0, WORKED, '{33'd0, 31'd0, 1'b1}},
		'{-32768, 0, 32767, 0, WORKED, '{33'd0, 31'd0, 1'b1}},
		'{1, 2, -1, 2, WORKED, '{33'd0, 31'd1, 1'b0}},
		'{32767, 1, 32767, 1, WORKED, '{33'd65534, 31'd1, 1'b0}},
		'{-32768, 1, -32768, 1, WORKED, '{-33'sd65536, 31'd1, 1'b0}},
		'{5, 1, 7, 1, WORKED, '{33'd12, 31'd1, 1'b0}},
		'{1, -2, 1, 2, WORKED, '{33'd0, 31'd1, 1'b0}},
		'{1, -3, 0, 1, WORKED, '{-33'sd1, 31'd3, 1'b0}},
		'{-32768, -32768, -32768, -32768, WORKED, '{33'd2, 31'd1, 1'b0}},
		'{-1, -1, -1, -1, WORKED, '{33'd2, 31'd1, 1'b0}},
		'{32767, 32767, 32767, 32767, WORKED, '{33'd2, 31'd1, 1'b0}},
		'{0, -5, 0, -7, WORKED, '{33'd0, 31'd1, 1'b0}},
		'{-32768, 1, 32767, 1, WORKED, '{-33'sd1, 31'd1, 1'b0}},
		'{32767, -32768, -32768, 32767, PREDICT, '0},
		'{-32768, 32767, -32768, -32768, PREDICT, '0},
		'{1, -32768, 1, -32768, PREDICT, '0},
		'{1, 32767, 1, -32768, PREDICT, '0},
		'{3, 7, 5, 11, PREDICT, '0},
		'{12, 18, -4, 6, PREDICT, '0},
		'{1, -32768, 0, -32768, PREDICT, '0},
		'{-32767, 32767, 32767, -32767, PREDICT, '0}
	};

	rational_add_reduce_top #(
		.OPERAND_BITS(OPERAND_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.a_num(a_num),
		.a_den(a_den),
		.b_num(b_num),
		.b_den(b_den),
		.done(done),
		.sum_num(sum_num),
		.sum_den(sum_den),
		.den_error(den_error)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Cross-multiply, reduce by Euclid's remainder loop, put the sign on the numerator
	function automatic sum_t reduced_sum(logic signed [OPERAND_BITS-1:0] an,
			logic signed [OPERAND_BITS-1:0] ad, logic signed [OPERAND_BITS-1:0] bn,
			logic signed [OPERAND_BITS-1:0] bd);
		longint          n;
		longint          d;
		longint unsigned nm;
		longint unsigned dm;
		longint unsigned x;
		longint unsigned y;
		longint unsigned r;
		sum_t            s;
		s = '0;
		if (ad == 0 || bd == 0) begin
			s.err = 1'b1;
			return s;
		end
		n = longint'(an) * longint'(bd) + longint'(ad) * longint'(bn);
		d = longint'(ad) * longint'(bd);
		nm = (n < 0) ? -n : n;
		dm = (d < 0) ? -d : d;
		x = nm;
		y = dm;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		nm = nm / x;
		dm = dm / x;
		if (nm != 0)
			s.num = ((n < 0) != (d < 0)) ? NUM_W'(-nm) : NUM_W'(nm);
		s.den = DEN_W'(dm);
		return s;
	endfunction

	function automatic int full_val();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic int small_val(int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	function automatic int extreme_val();
		case ($urandom_range(0, 5))
			0: return -32768;
			1: return -32767;
			2: return -1;
			3: return 0;
			4: return 1;
			default: return 32767;
		endcase
	endfunction

	// Hold start low for the gap between bursts, with noise on the operands
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 3))
				0: gap = 0;
				1, 2: gap = $urandom_range(1, 12);
				default: gap = $urandom_range(13, 200);
			endcase
			repeat (gap) begin
				@(negedge clk);
				start = 1'b0;
				a_num = OPERAND_BITS'(full_val());
				a_den = OPERAND_BITS'(full_val());
				b_num = OPERAND_BITS'(full_val());
				b_den = OPERAND_BITS'(full_val());
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
	endtask

	// Present one item and hold it until accepted, then queue its expected sum
	task automatic issue_item(int an, int ad, int bn, int bd, bit kind, sum_t res);
		pace();
		@(negedge clk);
		start = 1'b1;
		a_num = OPERAND_BITS'(an);
		a_den = OPERAND_BITS'(ad);
		b_num = OPERAND_BITS'(bn);
		b_den = OPERAND_BITS'(bd);
		do
			@(posedge clk);
		while (busy);
		pending_sums.push_back(kind == WORKED ? res : reduced_sum(a_num, a_den, b_num, b_den));
	endtask

	// Stimulus: reset, directed table, random items, drain
	initial begin
		int an;
		int ad;
		int bn;
		int bd;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			issue_item(dir_rows[i].an, dir_rows[i].ad, dir_rows[i].bn, dir_rows[i].bd,
				dir_rows[i].kind, dir_rows[i].res);

		for (int k = 0; k < ITEM_COUNT; k++) begin
			an = full_val();
			ad = full_val();
			bn = full_val();
			bd = full_val();
			case ($urandom_range(0, 99)) inside
				[0:4]: begin
					// zero denominator on one side or both
					case ($urandom_range(0, 2))
						0: ad = 0;
						1: bd = 0;
						default: begin
							ad = 0;
							bd = 0;
						end
					endcase
				end
				[5:24]: bd = 1;
				[25:54]: begin
					an = small_val(64);
					bn = small_val(64);
					do ad = small_val(64); while (ad == 0);
					do bd = small_val(64); while (bd == 0);
				end
				[55:64]: begin
					an = extreme_val();
					bn = extreme_val();
					do ad = extreme_val(); while (ad == 0);
					do bd = extreme_val(); while (bd == 0);
				end
				[65:74]: begin
					// opposite fractions cancel to zero
					bn = -an;
					bd = ad;
				end
				default: ;
			endcase
			issue_item(an, ad, bn, bd, PREDICT, '0);
		end

		@(negedge clk);
		start = 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_sums.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Compare each strobed result with the oldest expected sum
	always @(posedge clk) begin
		sum_t want;
		if (arst_n && done) begin
			if (pending_sums.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected sum %0d/%0d err %0b", sum_num, sum_den, den_error);
			end else begin
				want = pending_sums.pop_front();
				if (sum_num !== want.num || sum_den !== want.den || den_error !== want.err) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("sum mismatch: expected %0d/%0d err %0b, got %0d/%0d err %0b",
							$signed(want.num), want.den, want.err, sum_num, sum_den, den_error);
				end
			end
		end
	end

	// Stop a hung run
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/rar_pkg.sv
hw/rtl/rational_add_reduce_top.sv
tb/tb.sv
